/* sv/cps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;

   localparam int unsigned ID_W    = 4;
   localparam int unsigned BURST_W = 10;
   localparam int unsigned OUT_T_W = 16;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned QUANT_W = 8;
   localparam int unsigned CSR_W   = 8;
   localparam int unsigned CSR_A_W = 1;

   localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SRTF = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   localparam logic [CSR_A_W-1:0] CSR_MODE    = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_QUANTUM = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [ID_W-1:0]     proc_id;
      logic [BURST_W-1:0]  burst_length;
   } req_type;

   typedef struct packed {
      logic [OUT_T_W-1:0]  time_now;
      logic [ID_W-1:0]     running_id;
      logic                idle;
      logic                finished;
      logic                first_dispatch;
      logic                preempted;
      logic [ID_W-1:0]     preempted_id;
      logic                add_rejected;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/cps_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cps_req_if;
   import cps_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cps_rsp_if;
   import cps_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/cpu_process_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// an add passes through ST_OUT before its result beat, a tick first scans the
// whole table (ST_SCAN, ST_LAST, ST_EXEC, ST_OUT); one item is in flight at a time
// the rate of items is set by the one-entry-a-cycle scan of the ready table
// memory through its single read port and by the result beat leaving before
// the next item is taken
// reset: synchronous active high; clears valid bits, running slot, counters; sets csrs to FCFS mode, quantum 2
module cpu_process_scheduler_top #(
   parameter int unsigned MAX_PROCS = 16,
   parameter int unsigned TIME_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   cps_req_if.sink                    req,
   cps_rsp_if.source                  rsp,
   input  wire                        csr_we,
   input  wire [cps_pkg::CSR_A_W-1:0] csr_index,
   input  wire [cps_pkg::CSR_W-1:0]   csr_wdata
);
   import cps_pkg::*;

   localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
   localparam int unsigned ENT_W = ID_W + BURST_W + TIME_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_LAST  = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]      pid;
      logic [BURST_W-1:0]   rem;
      logic [TIME_BITS-1:0] stamp;
   } entry_type;

   // ready table: one synchronous memory, valid bits in flops
   entry_type              mem [MAX_PROCS];
   entry_type              rd_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   logic [MAX_PROCS-1:0]   valid_ff, valid_in;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;       // next address to issue
   logic [IDX_W-1:0]       chk_ff, chk_in;       // index of data now in rd_ff
   logic                   best_ok_ff, best_ok_in;
   logic [IDX_W-1:0]       best_ix_ff, best_ix_in;
   entry_type              best_ff, best_in;

   logic [MODE_W-1:0]      mode_ff;
   logic [QUANT_W-1:0]     quant_ff;
   logic                   run_v_ff, run_v_in;
   logic [ID_W-1:0]        run_pid_ff, run_pid_in;
   logic [BURST_W-1:0]     run_rem_ff, run_rem_in;
   logic [QUANT_W-1:0]     slice_ff, slice_in;
   logic [TIME_BITS-1:0]   tick_ff, tick_in;
   logic [TIME_BITS-1:0]   snext_ff, snext_in;
   rsp_type                out_ff, out_in;
   logic                   out_v_ff, out_v_in;

   // lowest free slot
   logic                   free_ok;
   logic [IDX_W-1:0]       free_ix;
   always_comb begin
      free_ok = 1'b0;
      free_ix = '0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok = 1'b1;
            free_ix = IDX_W'(i);
         end
      end
   end

   // candidate compare for the scan
   logic                   by_len;
   logic                   cand_v;
   logic                   take;
   logic [TIME_BITS-1:0]   age_c, age_b;
   assign by_len = (mode_ff == MODE_SJF) || (mode_ff == MODE_SRTF);
   assign cand_v = valid_ff[chk_ff];
   assign age_c  = snext_ff - rd_ff.stamp;
   assign age_b  = snext_ff - best_ff.stamp;
   always_comb begin
      take = 1'b0;
      if (cand_v) begin
         if (!best_ok_ff)                                   take = 1'b1;
         else if (by_len && rd_ff.rem < best_ff.rem)        take = 1'b1;
         else if ((!by_len || rd_ff.rem == best_ff.rem) && age_c > age_b) take = 1'b1;
      end
   end

   logic [QUANT_W-1:0] q_eff;
   assign q_eff = (quant_ff == '0) ? QUANT_W'(1) : quant_ff;

   // a new beat is taken only once the previous result beat is leaving
   assign req.ready = (state_ff == ST_IDLE) && (!out_v_ff || rsp.ready);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;
   // entry 0 is fetched while idle so the scan starts on it
   assign rd_addr   = (state_ff == ST_IDLE) ? '0 : cnt_ff[IDX_W-1:0];

   always_comb begin
      logic               pre;
      logic [BURST_W-1:0] rem_n;
      logic               rv;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      best_ok_in = best_ok_ff;
      best_ix_in = best_ix_ff;
      best_in    = best_ff;
      valid_in   = valid_ff;
      run_v_in   = run_v_ff;
      run_pid_in = run_pid_ff;
      run_rem_in = run_rem_ff;
      slice_in   = slice_ff;
      tick_in    = tick_ff;
      snext_in   = snext_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff;
      wr_en      = 1'b0;
      wr_addr    = free_ix;
      wr_data    = '0;
      pre        = 1'b0;
      rem_n      = '0;
      rv         = 1'b0;
      if (out_v_ff && rsp.ready) out_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cnt_in     = CNT_W'(1);
               chk_in     = '0;
               best_ok_in = 1'b0;
               state_in   = ST_SCAN;
               if (req.data.opcode == OP_ADD) begin
                  out_in              = '0;
                  out_in.time_now     = OUT_T_W'(tick_ff);
                  out_in.add_rejected = !free_ok;
                  if (free_ok) begin
                     wr_en          = 1'b1;
                     wr_data.pid    = req.data.proc_id;
                     wr_data.rem    = (req.data.burst_length == '0) ?
                                      BURST_W'(1) : req.data.burst_length;
                     wr_data.stamp  = snext_ff;
                     valid_in[free_ix] = 1'b1;
                     snext_in       = snext_ff + TIME_BITS'(1);
                  end
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            // rd_ff holds entry chk_ff
            if (take) begin
               best_ok_in = 1'b1;
               best_ix_in = chk_ff;
               best_in    = rd_ff;
            end
            chk_in = chk_ff + IDX_W'(1);
            if (cnt_ff == CNT_W'(MAX_PROCS)) state_in = ST_LAST;
            else cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_LAST: begin
            // every entry has been compared, best is settled
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            out_in          = '0;
            out_in.time_now = OUT_T_W'(tick_ff);
            run_pid_in      = run_pid_ff;
            run_rem_in      = run_rem_ff;
            slice_in        = slice_ff;
            rv              = run_v_ff;
            if (run_v_ff && mode_ff == MODE_SRTF)
               pre = best_ok_ff && best_ff.rem < run_rem_ff;
            else if (run_v_ff && mode_ff == MODE_RR && slice_ff >= q_eff) begin
               if (best_ok_ff) pre = 1'b1;
               else slice_in = '0;
            end
            if (pre) begin
               out_in.preempted      = 1'b1;
               out_in.preempted_id   = run_pid_ff;
               out_in.first_dispatch = 1'b1;
               wr_en         = 1'b1;
               wr_addr       = best_ix_ff;
               wr_data.pid   = run_pid_ff;
               wr_data.rem   = run_rem_ff;
               wr_data.stamp = snext_ff;
               snext_in      = snext_ff + TIME_BITS'(1);
               run_pid_in    = best_ff.pid;
               run_rem_in    = best_ff.rem;
               slice_in      = '0;
            end else if (!run_v_ff && best_ok_ff) begin
               valid_in[best_ix_ff]  = 1'b0;
               rv                    = 1'b1;
               run_pid_in            = best_ff.pid;
               run_rem_in            = best_ff.rem;
               slice_in              = '0;
               out_in.first_dispatch = 1'b1;
            end
            if (rv) begin
               out_in.running_id = run_pid_in;
               rem_n = (run_rem_in != '0) ? run_rem_in - BURST_W'(1) : run_rem_in;
               run_rem_in = rem_n;
               if (slice_in != '1) slice_in = slice_in + QUANT_W'(1);
               if (rem_n == '0) begin
                  out_in.finished = 1'b1;
                  rv = 1'b0;
               end
            end else begin
               out_in.idle = 1'b1;
            end
            run_v_in = rv;
            tick_in  = tick_ff + TIME_BITS'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_v_ff) begin
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         run_v_ff   <= 1'b0;
         run_pid_ff <= '0;
         run_rem_ff <= '0;
         slice_ff   <= '0;
         tick_ff    <= '0;
         snext_ff   <= '0;
         out_v_ff   <= 1'b0;
         mode_ff    <= MODE_FCFS;
         quant_ff   <= QUANT_W'(2);
         best_ok_ff <= 1'b0;
         cnt_ff     <= '0;
         chk_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         run_v_ff   <= run_v_in;
         run_pid_ff <= run_pid_in;
         run_rem_ff <= run_rem_in;
         slice_ff   <= slice_in;
         tick_ff    <= tick_in;
         snext_ff   <= snext_in;
         out_v_ff   <= out_v_in;
         best_ok_ff <= best_ok_in;
         cnt_ff     <= cnt_in;
         chk_ff     <= chk_in;
         if (csr_we && csr_index == CSR_MODE)    mode_ff  <= csr_wdata[MODE_W-1:0];
         if (csr_we && csr_index == CSR_QUANTUM) quant_ff <= csr_wdata[QUANT_W-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_ix_ff <= best_ix_in;
      best_ff    <= best_in;
      out_ff     <= out_in;
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !out_v_ff || rsp.ready || state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> tick_ff == $past(tick_ff) + TIME_BITS'(1))
      else $error("tick count did not advance");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && out_in.finished |=> !run_v_ff)
      else $error("finished process still running");
   a_pre_rr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && out_in.preempted |-> best_ok_ff && run_v_ff)
      else $error("preempt without candidate");
`endif
endmodule
`default_nettype wire

/* dv/cpu_process_scheduler_scoreboard.sv */
`timescale 1ns / 1ps
// ready-table scheduler predictor and expected-response store
class sched_scoreboard;
   localparam int NPROC = 16;

   logic [1:0]  mode_r;
   logic [7:0]  quantum_r;
   bit          ent_valid [NPROC];
   logic [3:0]  ent_pid [NPROC];
   logic [9:0]  ent_rem [NPROC];
   logic [15:0] ent_stamp [NPROC];
   bit          run_valid;
   logic [3:0]  run_pid;
   logic [9:0]  run_rem;
   logic [7:0]  slice_used;
   logic [15:0] tick_count;
   logic [15:0] stamp_next;

   cps_pkg::rsp_type pending_rsp[$];
   int mismatches;

   function new();
      mode_r = cps_pkg::MODE_FCFS;
      quantum_r = 8'd2;
      for (int i = 0; i < NPROC; i++) ent_valid[i] = 0;
      run_valid = 0;
      run_pid = '0;
      run_rem = '0;
      slice_used = '0;
      tick_count = '0;
      stamp_next = '0;
      mismatches = 0;
   endfunction

   function void set_reg(logic idx, logic [7:0] val);
      if (idx == cps_pkg::CSR_MODE) mode_r = val[1:0];
      else quantum_r = val;
   endfunction

   function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < NPROC; i++) if (!ent_valid[i]) n++;
      return n;
   endfunction

   function int choose_entry(bit by_len);
      int best;
      logic [15:0] age_i, age_b;
      best = -1;
      for (int i = 0; i < NPROC; i++) begin
         if (!ent_valid[i]) continue;
         if (best < 0) begin
            best = i;
            continue;
         end
         age_i = stamp_next - ent_stamp[i];
         age_b = stamp_next - ent_stamp[best];
         if (by_len && ent_rem[i] < ent_rem[best]) best = i;
         else if ((!by_len || ent_rem[i] == ent_rem[best]) && age_i > age_b) best = i;
      end
      return best;
   endfunction

   function void note_request(cps_pkg::req_type rq);
      cps_pkg::rsp_type r;
      int slot, c;
      bit by_len, pre;
      logic [7:0] q;
      logic [3:0] np;
      logic [9:0] nr;
      r = '0;
      r.time_now = tick_count;
      if (rq.opcode == cps_pkg::OP_ADD) begin
         slot = -1;
         for (int i = 0; i < NPROC; i++)
            if (!ent_valid[i] && slot < 0) slot = i;
         if (slot < 0) r.add_rejected = 1;
         else begin
            ent_valid[slot] = 1;
            ent_pid[slot] = rq.proc_id;
            ent_rem[slot] = (rq.burst_length == 0) ? 10'd1 : rq.burst_length;
            ent_stamp[slot] = stamp_next;
            stamp_next++;
         end
      end else begin
         by_len = (mode_r == cps_pkg::MODE_SJF || mode_r == cps_pkg::MODE_SRTF);
         q = (quantum_r == 0) ? 8'd1 : quantum_r;
         if (run_valid && (mode_r == cps_pkg::MODE_SRTF || mode_r == cps_pkg::MODE_RR)) begin
            c = choose_entry(by_len);
            pre = 0;
            if (mode_r == cps_pkg::MODE_SRTF) pre = (c >= 0) && (ent_rem[c] < run_rem);
            else if (slice_used >= q) begin
               if (c >= 0) pre = 1;
               else slice_used = 0;
            end
            if (pre) begin
               np = ent_pid[c];
               nr = ent_rem[c];
               r.preempted = 1;
               r.preempted_id = run_pid;
               ent_pid[c] = run_pid;
               ent_rem[c] = run_rem;
               ent_stamp[c] = stamp_next;
               stamp_next++;
               run_pid = np;
               run_rem = nr;
               slice_used = 0;
               r.first_dispatch = 1;
            end
         end
         if (!run_valid) begin
            c = choose_entry(by_len);
            if (c >= 0) begin
               ent_valid[c] = 0;
               run_valid = 1;
               run_pid = ent_pid[c];
               run_rem = ent_rem[c];
               slice_used = 0;
               r.first_dispatch = 1;
            end
         end
         if (run_valid) begin
            r.running_id = run_pid;
            if (run_rem > 0) run_rem--;
            if (slice_used < 8'd255) slice_used++;
            if (run_rem == 0) begin
               r.finished = 1;
               run_valid = 0;
            end
         end else r.idle = 1;
         tick_count++;
      end
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function void check_response(cps_pkg::rsp_type got);
      cps_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response beat %h", got);
         return;
      end
      want = pending_rsp[0];
      pending_rsp.delete(0);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: expected %p actual %p", want, got);
      end
   endfunction
endclass

/* dv/cpu_process_scheduler_top_test.sv */
`timescale 1ns / 1ps
module cpu_process_scheduler_top_test;
   import cps_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   // one item in flight, a tick scans the whole ready table
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_A_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   cps_req_if req_ch ();
   cps_rsp_if rsp_ch ();

   cpu_process_scheduler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sched_scoreboard sched_sb;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit, counted on every rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: sample on the rising edge, flip ready on the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sched_sb.check_response(rsp_ch.data);
   end

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one register write, only while the block is idle
   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sched_sb.set_reg(idx, val);
   endtask

   // present one beat; random idle cycles in front, held until accepted
   // valid stays up after acceptance until the next falling edge
   task automatic send_item(input logic op, input logic [3:0] id, input logic [9:0] burst);
      req_type rq;
      rq.opcode = op;
      rq.proc_id = id;
      rq.burst_length = burst;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= rq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sched_sb.note_request(rq);
   endtask

   // drop valid, wait for every expected beat, then the block's own latency
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sched_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic tick_run(input int n);
      repeat (n) send_item(OP_TICK, 4'd0, 10'd0);
   endtask

   // random mix: adds at 35 percent, the rest ticks, bursts mostly short
   task automatic random_phase(input int n);
      int k;
      logic [9:0] b;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 35) begin
            case ($urandom_range(9))
               0: b = 10'($urandom_range(1023));
               1: b = 10'd0;
               default: b = 10'($urandom_range(1, 6));
            endcase
            send_item(OP_ADD, 4'($urandom_range(15)), b);
         end else send_item(OP_TICK, 4'($urandom_range(15)), 10'($urandom_range(1023)));
      end
   endtask

   initial begin
      logic [1:0] m;
      sched_sb = new();
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fill the table past full, zero burst, extreme fields
      send_idle_pct = 19;
      recv_idle_pct = 71;
      write_reg(CSR_MODE, CSR_W'(MODE_FCFS));
      write_reg(CSR_QUANTUM, 8'd1);
      send_item(OP_ADD, 4'hF, 10'h3FF);
      send_item(OP_ADD, 4'h0, 10'd0);
      for (int i = 0; i < 15; i++) send_item(OP_ADD, i[3:0], 10'd1 + i[1:0]);
      send_item(OP_ADD, 4'h5, 10'h2AA); // table full, rejected
      send_item(OP_TICK, 4'hF, 10'h3FF);
      send_item(OP_TICK, 4'h0, 10'h155);
      // settle completely before switching to round robin
      drain();
      write_reg(CSR_MODE, CSR_W'(MODE_RR));
      tick_run(3);
      drain();
      write_reg(CSR_MODE, CSR_W'(MODE_SRTF));
      send_item(OP_ADD, 4'h3, 10'd1);
      tick_run(2);
      drain();
      write_reg(CSR_MODE, CSR_W'(MODE_SJF));
      write_reg(CSR_QUANTUM, 8'd0);

      // random phases over all modes and quanta, the extremes among them
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 71;
            recv_idle_pct = 19;
         end else if (ph == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         m = ph[1:0];
         write_reg(CSR_MODE, CSR_W'(m));
         case (ph % 3)
            0: write_reg(CSR_QUANTUM, 8'd255);
            1: write_reg(CSR_QUANTUM, 8'd1);
            default: write_reg(CSR_QUANTUM, 8'($urandom_range(255)));
         endcase
         random_phase(120);
      end

      drain();
      if (sched_sb.mismatches == 0 && sched_sb.pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/cps_pkg.sv
sv/cps_if.sv
sv/cpu_process_scheduler_top.sv
dv/cpu_process_scheduler_scoreboard.sv
dv/cpu_process_scheduler_top_test.sv
